// ===== src/mtc_pkg.sv =====
`timescale 1ns / 1ps
package mtc_pkg;

	// accumulator width and derived widths of the group arithmetic
	localparam int ACC_W      = 56;
	localparam int PROD_W     = 2 * ACC_W;
	localparam int HALF_W     = ACC_W / 2;
	localparam int OUT_W      = 18;
	localparam int QUO_W      = 17;
	localparam int SQRT_STEPS = ACC_W;
	localparam int DIV_STEPS  = QUO_W;
	localparam int CNT_W      = 6;

	// group queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;

	// register map
	localparam logic REG_CONJ_IDX = 1'b0;

	typedef struct packed {
		logic signed [ACC_W-1:0] cross_re;
		logic signed [ACC_W-1:0] cross_im;
		logic [ACC_W-1:0]        pwr_x;
		logic [ACC_W-1:0]        pwr_y;
	} mtc_sums_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_SQRT,
		B_DIV,
		B_DONE
	} mtc_bstate_t;

endpackage

// ===== src/mtc_front.sv =====
`timescale 1ns / 1ps
module mtc_front #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          conj,
	input  logic signed [SAMPLE_BITS-1:0] dx_re,
	input  logic signed [SAMPLE_BITS-1:0] dx_im,
	input  logic signed [SAMPLE_BITS-1:0] dy_re,
	input  logic signed [SAMPLE_BITS-1:0] dy_im,
	input  logic signed [SAMPLE_BITS-1:0] ykx_re,
	input  logic signed [SAMPLE_BITS-1:0] ykx_im,
	input  logic signed [SAMPLE_BITS-1:0] yky_re,
	input  logic signed [SAMPLE_BITS-1:0] yky_im,
	input  logic                          last_taper,
	output mtc_pkg::mtc_sums_t            sums,
	output logic                          sums_valid,
	output logic [1:0]                    lasts_in_flight
);

	localparam int S     = SAMPLE_BITS;
	localparam int P_W   = 2 * S;
	localparam int SUM_W = P_W + 1;
	localparam int R_W   = S + 2;
	localparam int T_W   = 2 * R_W;
	localparam int TS_W  = T_W + 1;
	localparam int EXT_W = mtc_pkg::ACC_W + 1;

	logic signed [P_W-1:0] prod_c [16];
	logic signed [P_W-1:0] prod_s1 [16];
	logic                  v_s1, v_s2, v_s3;
	logic                  last_s1, last_s2, last_s3;
	logic                  conj_s1;

	logic signed [R_W-1:0] w_re_s2, w_im_s2, e_re_s2, e_im_s2;
	logic signed [R_W-1:0] p_re_s2, p_im_s2, q_re_s2, q_im_s2;
	logic signed [T_W-1:0] m_s3 [8];

	logic signed [mtc_pkg::ACC_W-1:0] cross_re_q, cross_im_q;
	logic [mtc_pkg::ACC_W-1:0]        pwr_x_q, pwr_y_q;

	logic signed [TS_W-1:0]  t_re, t_im, t_px, t_py;
	logic signed [EXT_W-1:0] s_re, s_im;
	logic [EXT_W-1:0]        s_px, s_py;
	mtc_pkg::mtc_sums_t      nxt;

	// sum or difference of two products, then floor shift back to sample scale
	function automatic logic signed [R_W-1:0] fold(
		input logic signed [P_W-1:0] x,
		input logic signed [P_W-1:0] y,
		input logic                  sub
	);
		logic signed [SUM_W-1:0] t;
		t = sub ? ({x[P_W-1], x} - {y[P_W-1], y}) : ({x[P_W-1], x} + {y[P_W-1], y});
		return t[SUM_W-1:S-1];
	endfunction

	function automatic logic signed [mtc_pkg::ACC_W-1:0] sat_s(
		input logic signed [EXT_W-1:0] v
	);
		if (v[EXT_W-1] != v[EXT_W-2]) begin
			return v[EXT_W-1] ? {1'b1, {(mtc_pkg::ACC_W-1){1'b0}}}
			                  : {1'b0, {(mtc_pkg::ACC_W-1){1'b1}}};
		end
		return v[mtc_pkg::ACC_W-1:0];
	endfunction

	function automatic logic [mtc_pkg::ACC_W-1:0] sat_u(input logic [EXT_W-1:0] v);
		return v[EXT_W-1] ? {mtc_pkg::ACC_W{1'b1}} : v[mtc_pkg::ACC_W-1:0];
	endfunction

	// stage 0: the sixteen sample products
	always_comb begin
		prod_c[0]  = dx_re * dy_re;
		prod_c[1]  = dx_im * dy_im;
		prod_c[2]  = dx_re * dy_im;
		prod_c[3]  = dx_im * dy_re;
		prod_c[4]  = ykx_re * yky_re;
		prod_c[5]  = ykx_im * yky_im;
		prod_c[6]  = ykx_im * yky_re;
		prod_c[7]  = ykx_re * yky_im;
		prod_c[8]  = dx_re * ykx_re;
		prod_c[9]  = dx_im * ykx_im;
		prod_c[10] = dx_re * ykx_im;
		prod_c[11] = dx_im * ykx_re;
		prod_c[12] = dy_re * yky_re;
		prod_c[13] = dy_im * yky_im;
		prod_c[14] = dy_re * yky_im;
		prod_c[15] = dy_im * yky_re;
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			prod_s1 <= prod_c;
			conj_s1 <= conj;
			last_s1 <= last_taper;
		end
		if (v_s1) begin
			w_re_s2 <= fold(prod_s1[0], prod_s1[1], 1'b1);
			w_im_s2 <= fold(prod_s1[2], prod_s1[3], 1'b0);
			e_re_s2 <= fold(prod_s1[4], prod_s1[5], !conj_s1);
			e_im_s2 <= fold(prod_s1[6], prod_s1[7], conj_s1);
			p_re_s2 <= fold(prod_s1[8], prod_s1[9], 1'b1);
			p_im_s2 <= fold(prod_s1[10], prod_s1[11], 1'b0);
			q_re_s2 <= fold(prod_s1[12], prod_s1[13], 1'b1);
			q_im_s2 <= fold(prod_s1[14], prod_s1[15], 1'b0);
			last_s2 <= last_s1;
		end
		if (v_s2) begin
			m_s3[0] <= w_re_s2 * e_re_s2;
			m_s3[1] <= w_im_s2 * e_im_s2;
			m_s3[2] <= w_re_s2 * e_im_s2;
			m_s3[3] <= w_im_s2 * e_re_s2;
			m_s3[4] <= p_re_s2 * p_re_s2;
			m_s3[5] <= p_im_s2 * p_im_s2;
			m_s3[6] <= q_re_s2 * q_re_s2;
			m_s3[7] <= q_im_s2 * q_im_s2;
			last_s3 <= last_s2;
		end
	end

	// stage 3: saturating accumulate
	always_comb begin
		t_re = {m_s3[0][T_W-1], m_s3[0]} - {m_s3[1][T_W-1], m_s3[1]};
		t_im = {m_s3[2][T_W-1], m_s3[2]} + {m_s3[3][T_W-1], m_s3[3]};
		t_px = {m_s3[4][T_W-1], m_s3[4]} + {m_s3[5][T_W-1], m_s3[5]};
		t_py = {m_s3[6][T_W-1], m_s3[6]} + {m_s3[7][T_W-1], m_s3[7]};
		s_re = {cross_re_q[mtc_pkg::ACC_W-1], cross_re_q}
		     + {{(EXT_W-TS_W){t_re[TS_W-1]}}, t_re};
		s_im = {cross_im_q[mtc_pkg::ACC_W-1], cross_im_q}
		     + {{(EXT_W-TS_W){t_im[TS_W-1]}}, t_im};
		s_px = {1'b0, pwr_x_q} + {{(EXT_W-T_W){1'b0}}, t_px[T_W-1:0]};
		s_py = {1'b0, pwr_y_q} + {{(EXT_W-T_W){1'b0}}, t_py[T_W-1:0]};
		nxt.cross_re = sat_s(s_re);
		nxt.cross_im = sat_s(s_im);
		nxt.pwr_x    = sat_u(s_px);
		nxt.pwr_y    = sat_u(s_py);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			cross_re_q <= '0;
			cross_im_q <= '0;
			pwr_x_q    <= '0;
			pwr_y_q    <= '0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				if (last_s3) begin
					cross_re_q <= '0;
					cross_im_q <= '0;
					pwr_x_q    <= '0;
					pwr_y_q    <= '0;
				end else begin
					cross_re_q <= nxt.cross_re;
					cross_im_q <= nxt.cross_im;
					pwr_x_q    <= nxt.pwr_x;
					pwr_y_q    <= nxt.pwr_y;
				end
			end
		end
	end

	assign sums       = nxt;
	assign sums_valid = v_s3 && last_s3;
	assign lasts_in_flight = 2'(v_s1 && last_s1) + 2'(v_s2 && last_s2)
	                       + 2'(v_s3 && last_s3);

endmodule

// ===== src/mtc_queue.sv =====
`timescale 1ns / 1ps
module mtc_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  mtc_pkg::mtc_sums_t          wr_data,
	input  logic                        rd_en,
	output mtc_pkg::mtc_sums_t          rd_data,
	output logic                        q_empty,
	output logic [mtc_pkg::Q_PTR_W:0]   count
);

	mtc_pkg::mtc_sums_t              mem_q [mtc_pkg::Q_DEPTH];
	logic [mtc_pkg::Q_PTR_W-1:0]     wp_q, rp_q;
	logic [mtc_pkg::Q_PTR_W:0]       cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (mtc_pkg::Q_PTR_W+1)'(wr_en) - (mtc_pkg::Q_PTR_W+1)'(rd_en);
		end
	end

	assign rd_data = mem_q[rp_q];
	assign q_empty = (cnt_q == '0);
	assign count   = cnt_q;

endmodule

// ===== src/mtc_back.sv =====
`timescale 1ns / 1ps
module mtc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mtc_pkg::mtc_sums_t                grp,
	input  logic                              q_empty,
	output logic                              q_pop,
	input  logic                              pop,
	output logic                              empty,
	output logic signed [mtc_pkg::OUT_W-1:0]  coh_re,
	output logic signed [mtc_pkg::OUT_W-1:0]  coh_im,
	output logic                              zero_power
);

	localparam int A  = mtc_pkg::ACC_W;
	localparam int H  = mtc_pkg::HALF_W;
	localparam int PW = mtc_pkg::PROD_W;
	localparam int RW = A + 4;
	localparam int CW = mtc_pkg::CNT_W;
	localparam int QW = mtc_pkg::QUO_W;
	localparam int OW = mtc_pkg::OUT_W;

	typedef struct packed {
		logic load;
		logic mul_step;
		logic sqrt_step;
		logic div_step;
		logic emit;
	} mtc_bctl_t;

	mtc_pkg::mtc_bstate_t state_q, state_n;
	mtc_bctl_t            ctl;

	logic [CW-1:0]  cnt_q;
	logic [A-1:0]   px_q, py_q, num_re_q, num_im_q, dr_q, di_q, root_q;
	logic           neg_re_q, neg_im_q, zero_q, out_v_q;
	logic [PW-1:0]  prod_q;
	logic [RW-1:0]  rem_q;
	logic [QW-1:0]  qr_q, qi_q;
	logic signed [OW-1:0] coh_re_q, coh_im_q;
	logic           zp_q;

	logic           grp_zero, last_cnt, out_free;
	logic [H-1:0]   a_h, b_h;
	logic [A-1:0]   pp;
	logic [PW-1:0]  pp_sh;
	logic [RW-1:0]  rem_n, trial;
	logic [A:0]     rs_re, rs_im;
	logic [OW-1:0]  res_re, res_im;

	function automatic logic [A-1:0] mag(input logic signed [A-1:0] x);
		return x[A-1] ? (~x + 1'b1) : x;
	endfunction

	// magnitude / den with rounding and clamp, then sign
	function automatic logic [OW-1:0] finish(
		input logic [A-1:0]  num,
		input logic [A-1:0]  den,
		input logic [QW-1:0] quo,
		input logic          neg
	);
		logic [OW-1:0] m;
		logic [QW:0]   r1;
		r1 = {1'b0, quo} + 1'b1;
		m  = (num >= den) ? OW'(65536) : {1'b0, r1[QW:1]};
		return neg ? (~m + 1'b1) : m;
	endfunction

	assign grp_zero = (grp.pwr_x == '0) || (grp.pwr_y == '0);
	assign out_free = !out_v_q || pop;

	always_comb begin
		last_cnt = 1'b0;
		case (state_q)
			mtc_pkg::B_MUL:  last_cnt = (cnt_q == CW'(3));
			mtc_pkg::B_SQRT: last_cnt = (cnt_q == CW'(mtc_pkg::SQRT_STEPS - 1));
			mtc_pkg::B_DIV:  last_cnt = (cnt_q == CW'(mtc_pkg::DIV_STEPS - 1));
			default:         last_cnt = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			mtc_pkg::B_IDLE: begin
				if (!q_empty) state_n = grp_zero ? mtc_pkg::B_DONE : mtc_pkg::B_MUL;
			end
			mtc_pkg::B_MUL: begin
				if (last_cnt) state_n = mtc_pkg::B_SQRT;
			end
			mtc_pkg::B_SQRT: begin
				if (last_cnt) state_n = mtc_pkg::B_DIV;
			end
			mtc_pkg::B_DIV: begin
				if (last_cnt) state_n = mtc_pkg::B_DONE;
			end
			mtc_pkg::B_DONE: begin
				if (out_free) state_n = mtc_pkg::B_IDLE;
			end
			default: state_n = mtc_pkg::B_IDLE;
		endcase
	end

	// control strobes
	always_comb begin
		ctl = '0;
		case (state_q)
			mtc_pkg::B_IDLE: ctl.load      = !q_empty;
			mtc_pkg::B_MUL:  ctl.mul_step  = 1'b1;
			mtc_pkg::B_SQRT: ctl.sqrt_step = 1'b1;
			mtc_pkg::B_DIV:  ctl.div_step  = 1'b1;
			mtc_pkg::B_DONE: ctl.emit      = out_free;
			default:         ctl = '0;
		endcase
	end

	assign q_pop = ctl.load;

	// datapath of one step
	always_comb begin
		a_h = cnt_q[1] ? px_q[A-1:H] : px_q[H-1:0];
		b_h = cnt_q[0] ? py_q[A-1:H] : py_q[H-1:0];
		pp  = a_h * b_h;
		case (cnt_q[1:0])
			2'b00:   pp_sh = {{(PW-A){1'b0}}, pp};
			2'b11:   pp_sh = {pp, {A{1'b0}}};
			default: pp_sh = {{(PW-A-H){1'b0}}, pp, {H{1'b0}}};
		endcase
		rem_n = {rem_q[RW-3:0], prod_q[PW-1:PW-2]};
		trial = {2'b00, root_q, 2'b01};
		rs_re = {dr_q, 1'b0};
		rs_im = {di_q, 1'b0};
		res_re = finish(num_re_q, root_q, qr_q, neg_re_q);
		res_im = finish(num_im_q, root_q, qi_q, neg_im_q);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			px_q     <= grp.pwr_x;
			py_q     <= grp.pwr_y;
			num_re_q <= mag(grp.cross_re);
			num_im_q <= mag(grp.cross_im);
			dr_q     <= mag(grp.cross_re);
			di_q     <= mag(grp.cross_im);
			neg_re_q <= grp.cross_re[A-1];
			neg_im_q <= grp.cross_im[A-1];
			zero_q   <= grp_zero;
			prod_q   <= '0;
			rem_q    <= '0;
			root_q   <= '0;
			qr_q     <= '0;
			qi_q     <= '0;
		end
		if (ctl.mul_step) begin
			prod_q <= prod_q + pp_sh;
		end
		if (ctl.sqrt_step) begin
			prod_q <= {prod_q[PW-3:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[A-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[A-2:0], 1'b0};
			end
		end
		if (ctl.div_step) begin
			if (rs_re >= {1'b0, root_q}) begin
				dr_q <= A'(rs_re - {1'b0, root_q});
				qr_q <= {qr_q[QW-2:0], 1'b1};
			end else begin
				dr_q <= rs_re[A-1:0];
				qr_q <= {qr_q[QW-2:0], 1'b0};
			end
			if (rs_im >= {1'b0, root_q}) begin
				di_q <= A'(rs_im - {1'b0, root_q});
				qi_q <= {qi_q[QW-2:0], 1'b1};
			end else begin
				di_q <= rs_im[A-1:0];
				qi_q <= {qi_q[QW-2:0], 1'b0};
			end
		end
		if (ctl.emit) begin
			coh_re_q <= zero_q ? '0 : res_re;
			coh_im_q <= zero_q ? '0 : res_im;
			zp_q     <= zero_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtc_pkg::B_IDLE;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctl.load || last_cnt) begin
				cnt_q <= '0;
			end else if (ctl.mul_step || ctl.sqrt_step || ctl.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (ctl.emit) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign empty      = !out_v_q;
	assign coh_re     = coh_re_q;
	assign coh_im     = coh_im_q;
	assign zero_power = zp_q;

endmodule

// ===== src/multitaper_coherency_accumulator.sv =====
`timescale 1ns / 1ps
// Multitaper coherency accumulator. Push one beat per taper; the beat with
// last_taper set closes the frequency pair, and afterwards one result
// beat appears: the accumulated cross spectrum over sqrt(Px*Py) with 16
// fractional bits, clamped to +-1.0, or zero with zero_power set when either
// power sum is zero. The front end is a three-stage multiply/accumulate pipe
// that takes a beat every cycle while full is low; closed groups wait in a
// two-entry queue and full rises only while that queue could overflow. The
// back end handles one group at a time: a load, the 56x56 power product from
// partial products of 28-bit halves, a bit-serial square root, a restoring
// divide of 17 quotient bits and a write of the result register; a zero power
// group goes from the load straight to the write. It loads no new group before
// its last result is written, and holds a result while the one before waits.
// conjugate_second sits at byte address 0 and resets to 1.
module multitaper_coherency_accumulator #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// input queue side
	input  logic                              push,
	output logic                              full,
	input  logic signed [SAMPLE_BITS-1:0]     dx_re,
	input  logic signed [SAMPLE_BITS-1:0]     dx_im,
	input  logic signed [SAMPLE_BITS-1:0]     dy_re,
	input  logic signed [SAMPLE_BITS-1:0]     dy_im,
	input  logic signed [SAMPLE_BITS-1:0]     ykx_re,
	input  logic signed [SAMPLE_BITS-1:0]     ykx_im,
	input  logic signed [SAMPLE_BITS-1:0]     yky_re,
	input  logic signed [SAMPLE_BITS-1:0]     yky_im,
	input  logic                              last_taper,
	// result queue side
	output logic                              empty,
	input  logic                              pop,
	output logic signed [mtc_pkg::OUT_W-1:0]  coh_re,
	output logic signed [mtc_pkg::OUT_W-1:0]  coh_im,
	output logic                              zero_power
);

	logic                            conj_q;
	logic                            in_take;
	mtc_pkg::mtc_sums_t              sums, head;
	logic                            sums_valid, q_empty, q_pop;
	logic [1:0]                      lasts;
	logic [mtc_pkg::Q_PTR_W:0]       q_count;
	logic [2:0]                      pending;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conj_q <= 1'b1;
		end else if (psel && penable && pwrite && (paddr[2] == mtc_pkg::REG_CONJ_IDX)) begin
			conj_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == mtc_pkg::REG_CONJ_IDX) ? {31'b0, conj_q} : 32'b0;
	assign pready = 1'b1;

	// closed groups in the pipe plus those already queued must fit the queue
	assign pending = 3'(q_count) + 3'(lasts);
	assign full    = (pending >= 3'(mtc_pkg::Q_DEPTH));
	assign in_take = push && !full;

	mtc_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_take),
		.conj            (conj_q),
		.dx_re           (dx_re),
		.dx_im           (dx_im),
		.dy_re           (dy_re),
		.dy_im           (dy_im),
		.ykx_re          (ykx_re),
		.ykx_im          (ykx_im),
		.yky_re          (yky_re),
		.yky_im          (yky_im),
		.last_taper      (last_taper),
		.sums            (sums),
		.sums_valid      (sums_valid),
		.lasts_in_flight (lasts)
	);

	mtc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (sums_valid),
		.wr_data (sums),
		.rd_en   (q_pop),
		.rd_data (head),
		.q_empty (q_empty),
		.count   (q_count)
	);

	mtc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.grp        (head),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.coh_re     (coh_re),
		.coh_im     (coh_im),
		.zero_power (zero_power)
	);

endmodule

// ===== src/mtc_checker.sv =====
`timescale 1ns / 1ps
module mtc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              empty,
	input logic                              pop,
	input logic                              pready,
	input logic signed [mtc_pkg::OUT_W-1:0]  coh_re,
	input logic signed [mtc_pkg::OUT_W-1:0]  coh_im,
	input logic                              zero_power
);

	// a zero power group carries a zero coherency
	a_zero_res: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && zero_power) |-> (coh_re == '0 && coh_im == '0))
		else $error("zero power result is not zero");

	// each coherency part stays within plus or minus one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (coh_re <= 18'sd65536 && coh_re >= -18'sd65536 &&
		            coh_im <= 18'sd65536 && coh_im >= -18'sd65536))
		else $error("coherency out of range");

	// a waiting result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(coh_re) && $stable(coh_im) &&
		                      $stable(zero_power)))
		else $error("result beat changed while waiting");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind multitaper_coherency_accumulator mtc_checker u_mtc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.pready     (pready),
	.coh_re     (coh_re),
	.coh_im     (coh_im),
	.zero_power (zero_power)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;

	// one taper beat as it goes into the block
	typedef struct packed {
		logic signed [15:0] dx_re;
		logic signed [15:0] dx_im;
		logic signed [15:0] dy_re;
		logic signed [15:0] dy_im;
		logic signed [15:0] ykx_re;
		logic signed [15:0] ykx_im;
		logic signed [15:0] yky_re;
		logic signed [15:0] yky_im;
		logic               last;
	} taper_t;

	// one coherency beat as it comes out
	typedef struct packed {
		logic signed [mtc_pkg::OUT_W-1:0] re;
		logic signed [mtc_pkg::OUT_W-1:0] im;
		logic                             zp;
	} coh_t;

	// directed row: the coherency is typed in only where it is obvious
	typedef struct packed {
		taper_t t;
		logic   typed;
		coh_t   c;
	} row_t;

	localparam longint CROSS_MAX = 64'sh007F_FFFF_FFFF_FFFF;
	localparam longint CROSS_MIN = -CROSS_MAX - 1;
	localparam longint PWR_MAX   = 64'sh00FF_FFFF_FFFF_FFFF;
	localparam longint UNITY     = 65536;
	localparam int     SHIFT     = 15;
	localparam int     MAX_GAP   = 11;
	localparam int     DRAIN_CYC = 120;
	localparam int     STALL_LIM = 3000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        push = 1'b0;
	logic        full;
	taper_t      beat = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic signed [mtc_pkg::OUT_W-1:0] coh_re, coh_im;
	logic        zero_power;

	// predictor state
	longint  cross_re_acc, cross_im_acc, pwr_x_acc, pwr_y_acc;
	bit      conj_on;
	coh_t    coh_expected[$];
	int      errors = 0;
	int      idle_cycles = 0;
	bit      calm_tx = 0, calm_rx = 0;
	row_t    rows[$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	multitaper_coherency_accumulator i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.push(push), .full(full),
		.dx_re(beat.dx_re), .dx_im(beat.dx_im), .dy_re(beat.dy_re), .dy_im(beat.dy_im),
		.ykx_re(beat.ykx_re), .ykx_im(beat.ykx_im),
		.yky_re(beat.yky_re), .yky_im(beat.yky_im), .last_taper(beat.last),
		.empty(empty), .pop(pop),
		.coh_re(coh_re), .coh_im(coh_im), .zero_power(zero_power)
	);

	task automatic report(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic longint cross_sat(input longint a, input longint b);
		longint r;
		r = a + b;
		if (r > CROSS_MAX) return CROSS_MAX;
		if (r < CROSS_MIN) return CROSS_MIN;
		return r;
	endfunction

	// floor(sqrt(px*py)), bit by bit over the 56 result bits
	function automatic longint root_of_product(input longint px, input longint py);
		logic [111:0] prod, t;
		logic [55:0]  y;
		prod = 112'(px) * 112'(py);
		y = '0;
		for (int b = 55; b >= 0; b--) begin
			t = 112'(y | (56'd1 << b));
			if (t * t <= prod) y = t[55:0];
		end
		return longint'(y);
	endfunction

	// num/den with 16 fractional bits, round half away, clamp to unity
	function automatic logic signed [mtc_pkg::OUT_W-1:0] coh_part(input longint num,
			input longint den);
		logic [79:0] r, d;
		longint      q, mag;
		bit          neg;
		neg = num < 0;
		r = neg ? 80'(-num) : 80'(num);
		d = 80'(den);
		q = 0;
		if (r >= d) mag = UNITY;
		else begin
			for (int i = 0; i < 17; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= d) begin
					r = r - d;
					q = q | 1;
				end
			end
			mag = (q + 1) >>> 1;
			if (mag > UNITY) mag = UNITY;
		end
		return mtc_pkg::OUT_W'(neg ? -mag : mag);
	endfunction

	// folds one taper into the sums; returns 1 and the coherency on the last one
	function automatic bit fold_taper(input taper_t t, output coh_t c);
		longint a, b, cc, d, xr, xi, yr, yi, wr, wi, er, ei, pr, pi, qr, qi, den;
		a = t.dx_re; b = t.dx_im; cc = t.dy_re; d = t.dy_im;
		xr = t.ykx_re; xi = t.ykx_im; yr = t.yky_re; yi = t.yky_im;
		wr = (a * cc - b * d) >>> SHIFT;
		wi = (a * d + b * cc) >>> SHIFT;
		if (conj_on) begin
			er = (xr * yr + xi * yi) >>> SHIFT;
			ei = (xi * yr - xr * yi) >>> SHIFT;
		end else begin
			er = (xr * yr - xi * yi) >>> SHIFT;
			ei = (xr * yi + xi * yr) >>> SHIFT;
		end
		cross_re_acc = cross_sat(cross_re_acc, wr * er - wi * ei);
		cross_im_acc = cross_sat(cross_im_acc, wr * ei + wi * er);
		pr = (a * xr - b * xi) >>> SHIFT;
		pi = (a * xi + b * xr) >>> SHIFT;
		qr = (cc * yr - d * yi) >>> SHIFT;
		qi = (cc * yi + d * yr) >>> SHIFT;
		pwr_x_acc += pr * pr + pi * pi;
		pwr_y_acc += qr * qr + qi * qi;
		if (pwr_x_acc > PWR_MAX) pwr_x_acc = PWR_MAX;
		if (pwr_y_acc > PWR_MAX) pwr_y_acc = PWR_MAX;
		c = '0;
		if (!t.last) return 0;
		if (pwr_x_acc == 0 || pwr_y_acc == 0) c.zp = 1'b1;
		else begin
			den = root_of_product(pwr_x_acc, pwr_y_acc);
			c.re = coh_part(cross_re_acc, den);
			c.im = coh_part(cross_im_acc, den);
		end
		cross_re_acc = 0; cross_im_acc = 0; pwr_x_acc = 0; pwr_y_acc = 0;
		return 1;
	endfunction

	// sample value: mostly full range, some extremes, some small
	function automatic logic signed [15:0] rand_sample();
		int k;
		k = $urandom_range(0, 99);
		if (k < 70) return 16'($urandom);
		if (k < 85) case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return -16'sd1;
			default: return 16'sd1;
		endcase
		return 16'($signed($urandom_range(0, 511)) - 256);
	endfunction

	function automatic taper_t mk(input int dr, di, er, ei, xr, xi, yr, yi, bit l);
		taper_t t;
		t = {16'(dr), 16'(di), 16'(er), 16'(ei), 16'(xr), 16'(xi), 16'(yr), 16'(yi), l};
		return t;
	endfunction

	// push one beat; a gap of zero keeps push high across beats
	task automatic push_beat(input taper_t t, input row_t r);
		int gap;
		coh_t c;
		gap = calm_tx ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		beat <= t;
		do @(posedge clk); while (full);
		if (fold_taper(t, c)) coh_expected.push_back(r.typed ? r.c : c);
	endtask

	// wait for every result, then for the back end to settle
	task automatic drain();
		push <= 1'b0;
		wait (coh_expected.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_conj(input bit v);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 3'(mtc_pkg::REG_CONJ_IDX) << 2; pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		conj_on = v;
	endtask

	task automatic random_groups(input int n_beats);
		int sent, len;
		taper_t t;
		row_t nr;
		sent = 0;
		nr = '0;
		while (sent < n_beats) begin
			len = ($urandom_range(0, 19) == 0) ? 8 : $urandom_range(1, 5);
			if ($urandom_range(0, 9) == 0) calm_tx = ~calm_tx;
			for (int i = 0; i < len; i++) begin
				t = {rand_sample(), rand_sample(), rand_sample(), rand_sample(),
					rand_sample(), rand_sample(), rand_sample(), rand_sample(),
					1'b0};
				// now and then a dead first series, giving a zero power group
				if ($urandom_range(0, 29) == 0) begin
					t.dx_re = 0; t.dx_im = 0;
				end
				t.last = (i == len - 1);
				push_beat(t, nr);
			end
			sent += len;
		end
	endtask

	// result side: random stall per beat, checked at the accepting edge
	initial begin
		int stall;
		coh_t want;
		@(posedge arst_n);
		forever begin
			stall = calm_rx ? 0 : $urandom_range(0, MAX_GAP);
			if ($urandom_range(0, 15) == 0) calm_rx = ~calm_rx;
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (coh_expected.size() == 0) report("coherency beat with nothing expected");
			else begin
				want = coh_expected.pop_front();
				if (coh_re !== want.re)
					report($sformatf("coh_re %0d, want %0d", coh_re, want.re));
				if (coh_im !== want.im)
					report($sformatf("coh_im %0d, want %0d", coh_im, want.im));
				if (zero_power !== want.zp)
					report($sformatf("zero_power %0b, want %0b", zero_power, want.zp));
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIM) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		taper_t g;
		cross_re_acc = 0; cross_im_acc = 0; pwr_x_acc = 0; pwr_y_acc = 0;
		conj_on = 1'b1;

		// all zero, and a dead first weight: both give zero power
		rows.push_back({mk(0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1, coh_t'{0, 0, 1}});
		rows.push_back({mk(0, 0, 32767, -32768, 32767, -32768, 32767, 32767, 1),
			1'b1, coh_t'{0, 0, 1}});
		// dead second eigencoefficient
		rows.push_back({mk(32767, 1, 32767, 1, 500, 500, 0, 0, 1), 1'b1, coh_t'{0, 0, 1}});
		// extremes of every sample
		rows.push_back({mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1),
			1'b0, coh_t'('0)});
		rows.push_back({mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
			-32768, 1), 1'b0, coh_t'('0)});
		rows.push_back({mk(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768, 1),
			1'b0, coh_t'('0)});
		rows.push_back({mk(32767, 0, 32767, 0, 1000, 0, 1000, 0, 1), 1'b0, coh_t'('0)});
		rows.push_back({mk(32767, 0, 32767, 0, 0, 1000, 1000, 0, 1), 1'b0, coh_t'('0)});
		rows.push_back({mk(-1, -1, 1, 1, -1, 1, -1, 1, 1), 1'b0, coh_t'('0)});
		// a four taper group with mixed signs
		rows.push_back({mk(23170, 0, 23170, 0, 1200, -300, 900, 50, 0), 1'b0, coh_t'('0)});
		rows.push_back({mk(16384, 16384, 16384, -16384, -700, 2000, 800, -1500, 0),
			1'b0, coh_t'('0)});
		rows.push_back({mk(-32768, 100, 5, 32767, 32767, -32768, -5, 12, 0),
			1'b0, coh_t'('0)});
		rows.push_back({mk(12000, -9000, -30000, 200, 17, -17, 25000, -25000, 1),
			1'b0, coh_t'('0)});
		// zero rows inside a group do not move the sums
		rows.push_back({mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, coh_t'('0)});
		rows.push_back({mk(8192, 0, 8192, 0, 4000, 4000, 4000, -4000, 1), 1'b0, coh_t'('0)});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) push_beat(rows[i].t, rows[i]);
		drain();

		// random phases, flipping the conjugation between them
		write_conj(1'b0);
		random_groups(400);
		drain();
		write_conj(1'b1);
		random_groups(400);
		drain();
		write_conj(1'b0);
		// the same group under plain second coefficient
		g = mk(32767, 0, 32767, 0, 0, 1000, 1000, 0, 1);
		push_beat(g, '0);
		random_groups(350);
		drain();
		write_conj(1'b1);
		random_groups(380);

		drain();
		if (errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
